// ===== sv/cnmdt_pkg.sv =====
// shared types and constants for canny non-maximum suppression with double threshold
package cnmdt_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SIZE_W = 13;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_STRONG_LEVEL = 2'd2,
		REG_WEAK_LEVEL = 2'd3
	} cfg_reg_t;

	localparam logic [2:0] DIR_HORZ = 3'd1;
	localparam logic [2:0] DIR_SLASH = 3'd2;
	localparam logic [2:0] DIR_VERT = 3'd3;
	localparam logic [2:0] DIR_BACKSLASH = 3'd4;

	localparam logic [1:0] CLASS_NONE = 2'd0;
	localparam logic [1:0] CLASS_WEAK = 2'd1;
	localparam logic [1:0] CLASS_STRONG = 2'd2;

	localparam logic [7:0] HELD_START = 8'd255;

	localparam logic [10:0] WIDTH_RESET = 11'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [7:0] STRONG_RESET = 8'd30;
	localparam logic [7:0] WEAK_RESET = 8'd15;
	localparam logic [SIZE_W-1:0] MIN_SIZE = 13'd3;
	localparam logic [SIZE_W-1:0] MAX_HEIGHT = 13'd4096;

	typedef struct packed {
		logic [7:0] magnitude;
		logic [2:0] direction;
	} pixel_t;

	typedef struct packed {
		logic [11:0] row_index;
		logic [9:0] column_index;
		logic [1:0] edge_class;
		logic final_pixel;
	} result_t;

	typedef struct packed {
		logic [7:0] mag_a;
		logic [7:0] mag_b;
		logic [2:0] dir;
	} line_entry_t;

endpackage

// ===== sv/canny_nonmax_double_threshold.sv =====
// top level: line-buffered non-maximum suppression and double threshold classification
// One pixel per clock, sustained while the result output does not stall. An accepted pixel
// reads its column from a single line memory (two magnitude rows and one direction row per
// entry) in the accept cycle; when stage one then moves on, the window shifts, the column
// entry is written back and the result is registered: interior pixel (row, column) is
// reported on the beat of pixel (row + 1, column + 1). The write-back of a column follows its
// read and consecutive pixels never share a column, so the memory needs no interlock and the
// rate is set by its one write per pixel. Border pixels give no result beat. The line memory
// is not cleared after reset; the first two rows of an image fill it before any of it is
// used.
module canny_nonmax_double_threshold #(
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cnmdt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [cnmdt_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic pixel_valid,
	output logic pixel_ready,
	input cnmdt_pkg::pixel_t pixel,
	output logic result_valid,
	input logic result_ready,
	output cnmdt_pkg::result_t result
);
	import cnmdt_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_WIDTH);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [7:0] strong_q;
	logic [7:0] weak_q;

	logic [SIZE_W-1:0] eff_w;
	logic [SIZE_W-1:0] eff_h;

	logic [CW-1:0] col_q;
	logic [11:0] row_q;
	logic [SIZE_W-1:0] col_inc;
	logic [SIZE_W-1:0] row_inc;

	line_entry_t line_mem [MAX_WIDTH];
	line_entry_t rd_q;
	line_entry_t wr_entry;
	logic rd_en;
	logic mem_we;

	logic s1_valid_q;
	logic [7:0] mag_s1;
	logic [2:0] dir_s1;
	logic [11:0] row_s1;
	logic [CW-1:0] col_s1;

	logic [7:0] win_q [3][2];
	logic [2:0] dir_dly_q;
	logic [7:0] ahead_q;
	logic [7:0] behind_q;

	logic [SIZE_W-1:0] row_ext;
	logic [SIZE_W-1:0] col_ext;
	logic emit_s1;
	logic s1_go;
	logic accept;
	logic [7:0] centre;
	logic [7:0] ahead_d;
	logic [7:0] behind_d;
	logic [7:0] kept;
	logic [1:0] cls;
	result_t result_d;

	logic result_valid_q;
	result_t result_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			strong_q <= STRONG_RESET;
			weak_q <= WEAK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: width_q <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[12:0];
				REG_STRONG_LEVEL: strong_q <= cfg_data[7:0];
				REG_WEAK_LEVEL: weak_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = SIZE_W'(width_q);
		if (eff_w < MIN_SIZE) eff_w = MIN_SIZE;
		if (eff_w > MAX_W) eff_w = MAX_W;
		eff_h = height_q;
		if (eff_h < MIN_SIZE) eff_h = MIN_SIZE;
		if (eff_h > MAX_HEIGHT) eff_h = MAX_HEIGHT;
	end

	// handshake
	assign s1_go = s1_valid_q && (!emit_s1 || !result_valid_q || result_ready);
	assign pixel_ready = !s1_valid_q || s1_go;
	assign accept = pixel_valid && pixel_ready;

	// raster counters, advanced at accept
	assign col_inc = SIZE_W'(col_q) + SIZE_W'(1);
	assign row_inc = SIZE_W'(row_q) + SIZE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_h) ? 12'd0 : row_inc[11:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// line memory, read at accept, written back when stage one moves on
	assign rd_en = accept;
	assign mem_we = s1_go;
	assign wr_entry = '{mag_a: mag_s1, mag_b: rd_q.mag_a, dir: dir_s1};

	always_ff @(posedge clk) begin
		if (mem_we) line_mem[col_s1] <= wr_entry;
		if (rd_en) rd_q <= line_mem[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pixel_ready) begin
			s1_valid_q <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1 <= pixel.magnitude;
			dir_s1 <= pixel.direction;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// suppression and classification
	assign row_ext = SIZE_W'(row_s1);
	assign col_ext = SIZE_W'(col_s1);
	assign emit_s1 = (row_ext >= SIZE_W'(2)) && (col_ext >= SIZE_W'(2))
		&& (row_ext < eff_h) && (col_ext < eff_w);
	assign centre = win_q[1][1];

	always_comb begin
		if (col_s1 == '0) begin
			ahead_d = HELD_START;
			behind_d = HELD_START;
		end else begin
			ahead_d = ahead_q;
			behind_d = behind_q;
		end
		if (emit_s1) begin
			case (dir_dly_q)
				DIR_HORZ: begin
					ahead_d = rd_q.mag_a;
					behind_d = win_q[1][0];
				end
				DIR_SLASH: begin
					behind_d = rd_q.mag_b;
					ahead_d = win_q[2][0];
				end
				DIR_VERT: begin
					behind_d = win_q[0][1];
					ahead_d = win_q[2][1];
				end
				DIR_BACKSLASH: begin
					behind_d = win_q[0][0];
					ahead_d = mag_s1;
				end
				default: ;
			endcase
		end
		kept = (centre >= ahead_d && centre >= behind_d) ? centre : 8'd0;
		if (kept > strong_q) cls = CLASS_STRONG;
		else if (kept > weak_q) cls = CLASS_WEAK;
		else cls = CLASS_NONE;
		result_d.row_index = 12'(row_ext - SIZE_W'(1));
		result_d.column_index = 10'(col_ext - SIZE_W'(1));
		result_d.edge_class = cls;
		result_d.final_pixel = (row_ext == eff_h - SIZE_W'(1))
			&& (col_ext == eff_w - SIZE_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= '0;
				win_q[k][1] <= '0;
			end
			dir_dly_q <= '0;
			ahead_q <= HELD_START;
			behind_q <= HELD_START;
		end else if (s1_go) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
			end
			win_q[0][1] <= rd_q.mag_b;
			win_q[1][1] <= rd_q.mag_a;
			win_q[2][1] <= mag_s1;
			dir_dly_q <= rd_q.dir;
			ahead_q <= ahead_d;
			behind_q <= behind_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && emit_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_wb_read_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && rd_en) |-> (col_s1 != col_q))
		else $error("line memory write-back and read hit the same column");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_go && emit_s1 && result_valid_q && !result_ready))
		else $error("pending result overwritten");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted beat lost before stage one");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.row_index != 12'd0 && result.column_index != 10'd0))
		else $error("border pixel reported");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.edge_class == CLASS_NONE || result.edge_class == CLASS_WEAK
			|| result.edge_class == CLASS_STRONG))
		else $error("invalid edge class");
`endif

endmodule

// ===== bench/canny_nonmax_double_threshold_test.sv =====
// self-checking bench for line-buffered non-maximum suppression with double threshold
module canny_nonmax_double_threshold_test;
	import cnmdt_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int RANDOM_PIXELS = 1050;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT = 1000;

	class edge_scoreboard;
		bit [7:0] mag_row1 [LINE_DEPTH];
		bit [7:0] mag_row2 [LINE_DEPTH];
		bit [2:0] dir_row1 [LINE_DEPTH];
		bit [7:0] win [3][3];
		bit [7:0] ahead, behind;
		bit [2:0] dir_lag;
		int unsigned row_pos, col_pos;
		bit [10:0] width_reg;
		bit [12:0] height_reg;
		bit [7:0] strong_lvl, weak_lvl;
		result_t pending_edges [$];
		int unsigned mismatches, checked;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			strong_lvl = STRONG_RESET;
			weak_lvl = WEAK_RESET;
			ahead = HELD_START;
			behind = HELD_START;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH: width_reg = data[10:0];
				REG_IMAGE_HEIGHT: height_reg = data[12:0];
				REG_STRONG_LEVEL: strong_lvl = data[7:0];
				REG_WEAK_LEVEL: weak_lvl = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned frame_width();
			if (width_reg < MIN_SIZE)
				return MIN_SIZE;
			if (width_reg > LINE_DEPTH)
				return LINE_DEPTH;
			return width_reg;
		endfunction

		function int unsigned frame_height();
			if (height_reg < MIN_SIZE)
				return MIN_SIZE;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void take_pixel(pixel_t px);
			int unsigned w, h, col;
			bit [7:0] centre, kept;
			result_t r;
			w = frame_width();
			h = frame_height();
			col = col_pos % LINE_DEPTH;
			// neighbours for code none start at full scale on every row
			if (col_pos == 0) begin
				ahead = HELD_START;
				behind = HELD_START;
			end
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = mag_row2[col];
			win[1][2] = mag_row1[col];
			win[2][2] = px.magnitude;
			if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
				case (dir_lag)
					DIR_HORZ: begin
						ahead = win[1][2];
						behind = win[1][0];
					end
					DIR_SLASH: begin
						behind = win[0][2];
						ahead = win[2][0];
					end
					DIR_VERT: begin
						behind = win[0][1];
						ahead = win[2][1];
					end
					DIR_BACKSLASH: begin
						behind = win[0][0];
						ahead = win[2][2];
					end
					default: ;
				endcase
				centre = win[1][1];
				kept = (centre >= ahead && centre >= behind) ? centre : 8'd0;
				if (kept > strong_lvl)
					r.edge_class = CLASS_STRONG;
				else if (kept > weak_lvl)
					r.edge_class = CLASS_WEAK;
				else
					r.edge_class = CLASS_NONE;
				r.row_index = 12'(row_pos - 1);
				r.column_index = 10'(col_pos - 1);
				r.final_pixel = (row_pos == h - 1 && col_pos == w - 1);
				pending_edges.push_back(r);
			end
			dir_lag = dir_row1[col];
			dir_row1[col] = px.direction;
			mag_row2[col] = mag_row1[col];
			mag_row1[col] = px.magnitude;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h)
					row_pos = 0;
			end
		endfunction

		function void check_edge(result_t got);
			result_t want;
			if (pending_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: row %0d col %0d class %0d final %0d",
						got.row_index, got.column_index, got.edge_class, got.final_pixel);
				return;
			end
			want = pending_edges.pop_front();
			checked++;
			if (got.row_index !== want.row_index || got.column_index !== want.column_index ||
					got.edge_class !== want.edge_class || got.final_pixel !== want.final_pixel) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected row %0d col %0d class %0d final %0d,",
						want.row_index, want.column_index, want.edge_class, want.final_pixel,
						" got row %0d col %0d class %0d final %0d",
						got.row_index, got.column_index, got.edge_class, got.final_pixel);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	cfg_reg_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic pixel_valid;
	logic pixel_ready;
	pixel_t pixel;
	logic result_valid;
	logic result_ready;
	result_t result;

	edge_scoreboard board = new();
	bit calm;
	int unsigned stall_left;
	int unsigned quiet;
	int unsigned pixels_sent, frames, cfg_writes, mid_writes;
	bit [7:0] probe_levels [8] = '{8'd0, 8'd255, 8'd31, 8'd30, 8'd16, 8'd15, 8'd200, 8'd1};

	canny_nonmax_double_threshold uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #2 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic int unsigned pick_level();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 255 : 0;
		return $urandom_range(0, 255);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t px;
		int lvl;
		case ($urandom_range(0, 9))
			0: px.magnitude = 8'd0;
			1: px.magnitude = 8'd255;
			2, 3: begin
				lvl = int'($urandom_range(0, 1) ? board.strong_lvl : board.weak_lvl);
				lvl = lvl + int'($urandom_range(0, 2)) - 1;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 255)
					lvl = 255;
				px.magnitude = 8'(lvl);
			end
			default: px.magnitude = 8'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0)
			px.direction = 3'($urandom_range(5, 7));
		else
			px.direction = 3'($urandom_range(0, 4));
		return px;
	endfunction

	// bits above the register width carry junk
	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		case (idx)
			REG_IMAGE_WIDTH: data[10:0] = 11'(value);
			REG_IMAGE_HEIGHT: data[12:0] = 13'(value);
			default: data[7:0] = 8'(value);
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic send_pixel(pixel_t px);
		int unsigned gap;
		gap = pick_gap();
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (!pixel_ready);
		board.take_pixel(px);
		pixels_sent++;
	endtask

	// drain all pending beats, then let border pixels clear the pipeline
	task automatic settle();
		pixel_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (board.pending_edges.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// width can only shrink inside a frame so no unwritten line entry is read
	task automatic disturb_frame();
		int unsigned fw;
		settle();
		fw = board.frame_width();
		case ($urandom_range(0, 2))
			0: begin
				if (fw > 3)
					write_reg(REG_IMAGE_WIDTH, $urandom_range(3, fw - 1));
				else
					write_reg(REG_STRONG_LEVEL, pick_level());
			end
			1: write_reg(REG_IMAGE_HEIGHT, $urandom_range(3, board.row_pos + 3));
			default: write_reg(REG_WEAK_LEVEL, pick_level());
		endcase
		mid_writes++;
	endtask

	task automatic run_frame(int unsigned w_raw, int unsigned h_raw, bit disturb);
		int unsigned sent, cut, fw, fh;
		settle();
		write_reg(REG_IMAGE_WIDTH, w_raw);
		write_reg(REG_IMAGE_HEIGHT, h_raw);
		if ($urandom_range(0, 1))
			write_reg(REG_STRONG_LEVEL, pick_level());
		if ($urandom_range(0, 1))
			write_reg(REG_WEAK_LEVEL, pick_level());
		fw = board.frame_width();
		fh = board.frame_height();
		cut = disturb ? $urandom_range(2 * fw, fw * fh - 1) : 0;
		sent = 0;
		do begin
			if (disturb && sent == cut)
				disturb_frame();
			send_pixel(rand_pixel());
			sent++;
		end while (board.row_pos != 0 || board.col_pos != 0);
		frames++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_edge(result);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int unsigned start, w, h;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_ready = 1'b0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 5x5 frame at reset thresholds: every direction code, levels at the class bounds
		write_reg(REG_IMAGE_WIDTH, 5);
		write_reg(REG_IMAGE_HEIGHT, 5);
		for (int i = 0; i < 25; i++)
			send_pixel('{magnitude: probe_levels[i % 8], direction: 3'((i * 3) % 8)});
		frames++;

		// strong below weak (run_frame may redraw either level), sizes below the minimum
		settle();
		write_reg(REG_STRONG_LEVEL, 0);
		write_reg(REG_WEAK_LEVEL, 255);
		run_frame(2, 0, 1'b0);

		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 11) == 0)
				w = $urandom_range(0, 2);
			else if ($urandom_range(0, 7) == 0)
				w = $urandom_range(17, 48);
			else
				w = $urandom_range(3, 12);
			h = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			run_frame(w, h, $urandom_range(0, 5) == 0);
		end

		pixel_valid <= 1'b0;
		while (board.pending_edges.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d pixels in %0d frames, %0d result beats checked, %0d mismatches",
			pixels_sent, frames, board.checked, board.mismatches);
		$display("%0d register writes, %0d of them inside a frame", cfg_writes, mid_writes);
		if (board.mismatches == 0 && board.pending_edges.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
